### rtl/core/pcrs_pkg.sv
// Shared types and constants for the point-count range-sum unit.
// Used by every module in rtl/core and by the testbench; depends on nothing else.
package pcrs_pkg;

  localparam int FIELD_W = 11;
  localparam int SUM_W   = 32;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Operation codes carried on the op field of a transaction.
  localparam logic OP_INC   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_HI,
    ST_WALK_LO,
    ST_SUB,
    ST_INC,
    ST_TOT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_ACC,
    SEL_BUMP,
    SEL_DIFF,
    SEL_TOTAL
  } alu_sel_t;

  typedef struct packed {
    logic in_fire;
    logic is_query;
    logic inc_ok;
    logic qry_ok;
    logic walk_done;
    logic clear_done;
    logic out_free;
    logic cfg_we;
  } seq_stat_t;

  typedef struct packed {
    logic     in_ready;
    logic     clear_run;
    logic     walk_load;
    logic     load_lo;
    logic     walk_run;
    logic     walk_up;
    logic     acc_en;
    logic     hi_save;
    logic     sub_en;
    logic     tot_en;
    logic     out_load;
    alu_sel_t alu_sel;
  } seq_ctrl_t;

  typedef struct packed {
    logic rd_en;
    logic pend;
    logic done;
  } walk_flags_t;

endpackage

### rtl/core/pcrs_alu.sv
// Shared 32-bit adder/subtractor used by the accumulation, bump, difference and total steps of the sequencer.
// Depends on pcrs_pkg for the sum width.
module pcrs_alu import pcrs_pkg::*; (
  input  logic [SUM_W-1:0] a,
  input  logic [SUM_W-1:0] b,
  input  logic             sub,
  output logic [SUM_W-1:0] y
);

  always_comb begin
    if (sub) begin
      y = a - b;
    end else begin
      y = a + b;
    end
  end

endmodule

### rtl/core/pcrs_walk.sv
// Index walker of the binary indexed tree: issues one memory read per cycle
// along a prefix path (downwards) or an update path (upwards).
// Depends on pcrs_pkg for the control and flag structs.
module pcrs_walk import pcrs_pkg::*; #(
  parameter int MAX_POSITIONS = 1024,
  parameter int IW            = 12,
  parameter int AW            = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  seq_ctrl_t     ctrl,
  input  logic [IW-1:0] load_idx,
  output walk_flags_t   flags,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] pend_addr
);

  localparam logic [IW-1:0] MAX_I = IW'(MAX_POSITIONS);

  logic [IW-1:0] idx_r;
  logic [IW-1:0] idx_nxt;
  logic [IW-1:0] lowbit;
  logic [IW-1:0] idx_m1;
  logic          in_span;
  logic          issue;
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;

  always_comb begin
    lowbit  = idx_r & (~idx_r + IW'(1));
    idx_m1  = idx_r - IW'(1);
    rd_addr = idx_m1[AW-1:0];
    if (ctrl.walk_up) begin
      in_span = (idx_r != '0) && (idx_r <= MAX_I);
      idx_nxt = idx_r + lowbit;
    end else begin
      in_span = (idx_r != '0);
      idx_nxt = idx_r - lowbit;
    end
    issue       = ctrl.walk_run && in_span;
    flags.rd_en = issue;
    flags.pend  = pend_r;
    flags.done  = ctrl.walk_run && !issue;
    pend_addr   = pend_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (ctrl.walk_load) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.walk_load) begin
      idx_r <= load_idx;
    end else if (issue) begin
      idx_r       <= idx_nxt;
      pend_addr_r <= rd_addr;
    end
  end

endmodule

### rtl/core/pcrs_seq.sv
// Sequencer of the point-count range-sum unit: clearing pass, two prefix
// walks per query, one update walk per increment, result hand-off.
// Depends on pcrs_pkg for the state enum and control structs.
module pcrs_seq import pcrs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output seq_ctrl_t ctrl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (stat.cfg_we) begin
      state_nxt = ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (stat.clear_done) state_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (stat.in_fire) begin
            if (stat.is_query) begin
              state_nxt = stat.qry_ok ? ST_WALK_HI : ST_OUT;
            end else begin
              state_nxt = stat.inc_ok ? ST_INC : ST_OUT;
            end
          end
        end
        ST_WALK_HI: begin
          if (stat.walk_done) state_nxt = ST_WALK_LO;
        end
        ST_WALK_LO: begin
          if (stat.walk_done) state_nxt = ST_SUB;
        end
        ST_SUB: state_nxt = ST_OUT;
        ST_INC: begin
          if (stat.walk_done) state_nxt = ST_TOT;
        end
        ST_TOT: state_nxt = ST_OUT;
        ST_OUT: begin
          if (stat.out_free) state_nxt = ST_IDLE;
        end
        default: state_nxt = ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    ctrl         = '0;
    ctrl.alu_sel = SEL_ACC;
    unique case (state_r)
      ST_CLEAR: ctrl.clear_run = 1'b1;
      ST_IDLE: begin
        ctrl.in_ready  = 1'b1;
        ctrl.walk_load = stat.in_fire && (stat.is_query ? stat.qry_ok : stat.inc_ok);
      end
      ST_WALK_HI: begin
        ctrl.walk_run = 1'b1;
        ctrl.acc_en   = 1'b1;
        if (stat.walk_done) begin
          ctrl.hi_save   = 1'b1;
          ctrl.walk_load = 1'b1;
          ctrl.load_lo   = 1'b1;
        end
      end
      ST_WALK_LO: begin
        ctrl.walk_run = 1'b1;
        ctrl.acc_en   = 1'b1;
      end
      ST_SUB: begin
        ctrl.sub_en  = 1'b1;
        ctrl.alu_sel = SEL_DIFF;
      end
      ST_INC: begin
        ctrl.walk_run = 1'b1;
        ctrl.walk_up  = 1'b1;
        ctrl.alu_sel  = SEL_BUMP;
      end
      ST_TOT: begin
        ctrl.tot_en  = 1'b1;
        ctrl.alu_sel = SEL_TOTAL;
      end
      ST_OUT: ctrl.out_load = stat.out_free;
      default: ctrl.clear_run = 1'b0;
    endcase
  end

endmodule

### rtl/core/point_count_range_sum_tree_unit.sv
// Point-count range-sum unit: top level; depends on pcrs_pkg, pcrs_alu, pcrs_walk, pcrs_seq.
// An increment walks the tree once and a query walks it twice, at most one read per tree level.
// Throughput: one transaction at a time; the next is taken in the idle cycle after the result.
// Reset (synchronous, active low) and every size write start a clearing pass over all
// MAX_POSITIONS entries, one memory entry per cycle, during which no transaction is accepted.
module point_count_range_sum_tree_unit import pcrs_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [FIELD_W-1:0] in_position,
  input  logic [FIELD_W-1:0] in_range_low,
  input  logic [FIELD_W-1:0] in_range_high,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SUM_W-1:0]   out_sum,
  output logic               out_dropped
);

  // The counters live in a binary indexed tree over all MAX_POSITIONS slots.
  // Any tree that holds the same per-position counts answers every range sum
  // identically, since the total is capped and no partial sum can wrap.
  localparam int AW = $clog2(MAX_POSITIONS);
  // The upward walk may step beyond the last slot, up to twice MAX_POSITIONS, before it stops.
  localparam int IW = $clog2(MAX_POSITIONS) + 2;
  localparam int CW = (IW > FIELD_W) ? IW : FIELD_W;
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_POSITIONS);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_POSITIONS - 1);

  seq_ctrl_t   ctrl;
  seq_stat_t   stat;
  walk_flags_t wk;

  logic [CW-1:0]    size_r;
  logic [SUM_W-1:0] total_r;
  logic [SUM_W-1:0] acc_r;
  logic [SUM_W-1:0] acc_hi_r;
  logic [IW-1:0]    lo_m1_r;
  logic             drop_r;
  logic [AW-1:0]    clr_cnt_r;
  logic [SUM_W-1:0] rdata_r;
  logic [SUM_W-1:0] mem [MAX_POSITIONS];
  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_dropped_r;

  logic [CW-1:0]    n_w;
  logic [CW-1:0]    pos_w;
  logic [CW-1:0]    lo_c;
  logic [CW-1:0]    hi_c;
  logic [CW-1:0]    lo_c_m1;
  logic             inc_ok;
  logic             qry_ok;
  logic             in_fire;
  logic             clear_done;
  logic             out_free;
  logic [IW-1:0]    load_idx;
  logic [AW-1:0]    wk_rd_addr;
  logic [AW-1:0]    wk_pend_addr;
  logic [SUM_W-1:0] alu_a;
  logic [SUM_W-1:0] alu_b;
  logic             alu_sub;
  logic [SUM_W-1:0] alu_y;
  logic [SUM_W-1:0] acc_cur;
  logic             bump_wr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [SUM_W-1:0] wr_data;

  // Operand decode. A size of zero behaves as one position, and a size above
  // the capacity behaves as the capacity. Query ends are clipped to the
  // active span; an empty clipped range is answered at once with zero.
  always_comb begin
    if (size_r == '0) begin
      n_w = CW'(1);
    end else if (size_r > MAX_C) begin
      n_w = MAX_C;
    end else begin
      n_w = size_r;
    end
    pos_w   = CW'(in_position);
    lo_c    = (in_range_low == '0) ? CW'(1) : CW'(in_range_low);
    hi_c    = (CW'(in_range_high) > n_w) ? n_w : CW'(in_range_high);
    lo_c_m1 = lo_c - CW'(1);
    inc_ok  = (pos_w != '0) && (pos_w <= n_w) && (total_r != SUM_MAX);
    qry_ok  = (lo_c <= hi_c);
  end

  assign in_fire    = in_valid && ctrl.in_ready;
  assign clear_done = (clr_cnt_r == LAST_A);
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    stat.in_fire    = in_fire;
    stat.is_query   = (in_op == OP_QUERY);
    stat.inc_ok     = inc_ok;
    stat.qry_ok     = qry_ok;
    stat.walk_done  = wk.done;
    stat.clear_done = clear_done;
    stat.out_free   = out_free;
    stat.cfg_we     = cfg_we;
  end

  pcrs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // A query first walks the prefix ending at the high end, then the prefix
  // ending just below the low end; an increment walks upwards from the position.
  always_comb begin
    if (ctrl.load_lo) begin
      load_idx = lo_m1_r;
    end else if (in_op == OP_QUERY) begin
      load_idx = hi_c[IW-1:0];
    end else begin
      load_idx = pos_w[IW-1:0];
    end
  end

  pcrs_walk #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .IW            (IW),
    .AW            (AW)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .load_idx  (load_idx),
    .flags     (wk),
    .rd_addr   (wk_rd_addr),
    .pend_addr (wk_pend_addr)
  );

  // The single adder serves accumulation, the node bumps on the update path, the final
  // difference and the running total, each in its own sequencer step.
  always_comb begin
    unique case (ctrl.alu_sel)
      SEL_ACC: begin
        alu_a   = acc_r;
        alu_b   = rdata_r;
        alu_sub = 1'b0;
      end
      SEL_BUMP: begin
        alu_a   = rdata_r;
        alu_b   = SUM_W'(1);
        alu_sub = 1'b0;
      end
      SEL_DIFF: begin
        alu_a   = acc_hi_r;
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      SEL_TOTAL: begin
        alu_a   = total_r;
        alu_b   = SUM_W'(1);
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = acc_r;
        alu_b   = rdata_r;
        alu_sub = 1'b0;
      end
    endcase
  end

  pcrs_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  // The last read of a walk returns in the cycle that the walk finishes.
  assign acc_cur = wk.pend ? alu_y : acc_r;

  // Memory write port: zeros during the clearing pass, otherwise the bumped
  // node written back in the cycle after it was read.
  always_comb begin
    bump_wr = ctrl.walk_up && wk.pend;
    wr_en   = ctrl.clear_run || bump_wr;
    wr_addr = ctrl.clear_run ? clr_cnt_r : wk_pend_addr;
    wr_data = ctrl.clear_run ? '0 : alu_y;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wk.rd_en) begin
      rdata_r <= mem[wk_rd_addr];
    end
  end

  // Configuration, running total and clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= MAX_C;
      total_r   <= '0;
      clr_cnt_r <= '0;
    end else if (cfg_we) begin
      size_r    <= CW'(cfg_wdata);
      total_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (ctrl.tot_en) begin
        total_r <= alu_y;
      end
      if (ctrl.clear_run && !clear_done) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // Transaction working registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_r   <= '0;
      drop_r  <= (in_op == OP_INC) && !inc_ok;
      lo_m1_r <= lo_c_m1[IW-1:0];
    end else if (ctrl.hi_save) begin
      acc_hi_r <= acc_cur;
      acc_r    <= '0;
    end else if (ctrl.sub_en) begin
      acc_r <= alu_y;
    end else if (ctrl.acc_en && wk.pend) begin
      acc_r <= alu_y;
    end
  end

  // Output register: lets a new transaction start while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_sum_r     <= acc_r;
      out_dropped_r <= drop_r;
    end
  end

  assign in_ready    = ctrl.in_ready;
  assign out_valid   = out_valid_r;
  assign out_sum     = out_sum_r;
  assign out_dropped = out_dropped_r;

  // The total only grows between size writes; a wrap would mean the
  // saturation gate failed.
  a_total_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |=> total_r >= $past(total_r))
    else $error("running total decreased without a size write");

  // No tree read may be issued while the clearing pass owns the memory.
  a_no_read_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear_run |-> !wk.rd_en)
    else $error("tree read issued during clearing pass");

  // A bumped node is written back to the address read in the cycle before.
  a_bump_addr : assert property (@(posedge clk) disable iff (!rst_n)
    bump_wr |-> wk_pend_addr == $past(wk_rd_addr))
    else $error("bump write-back address mismatch");

  // A dropped increment always reports a zero sum.
  a_drop_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dropped_r) |-> out_sum_r == '0)
    else $error("dropped result with non-zero sum");

endmodule

### tb/pcrs_tree_checker.sv
`timescale 1ns / 1ps
// Result checker for the point-count range-sum unit. It watches the size register, input and
// result channels, keeps its own copy of the counters and compares every result field by field.
// Depends on pcrs_pkg for the field and sum widths and the operation codes.
module pcrs_tree_checker import pcrs_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_op,
  input  logic [FIELD_W-1:0] in_position,
  input  logic [FIELD_W-1:0] in_range_low,
  input  logic [FIELD_W-1:0] in_range_high,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [SUM_W-1:0]   out_sum,
  input  logic               out_dropped,
  output int                 mismatches,
  output int                 outstanding,
  output int                 queries_checked,
  output int                 nonzero_sums,
  output int                 increments_checked,
  output int                 drops_seen
);

  typedef struct packed {
    logic             is_query;
    logic [SUM_W-1:0] sum;
    logic             dropped;
  } tree_result_t;

  // A flat count per position is enough: every tree node is the sum of its leaves, and the
  // saturation rule guarantees that no sum ever wraps.
  logic [SUM_W-1:0] position_counts [1:MAX_POSITIONS];
  logic [SUM_W-1:0] grand_total;
  int               span;
  tree_result_t     expected_results [$];

  function automatic int span_of(logic [FIELD_W-1:0] value);
    if (value == '0) return 1;
    if (value > MAX_POSITIONS) return MAX_POSITIONS;
    return int'(value);
  endfunction

  function automatic void clear_counts();
    foreach (position_counts[p]) position_counts[p] = '0;
    grand_total = '0;
  endfunction

  function automatic tree_result_t predict_result(logic op, logic [FIELD_W-1:0] pos,
                                                  logic [FIELD_W-1:0] lo,
                                                  logic [FIELD_W-1:0] hi);
    tree_result_t r;
    int           first;
    int           last;
    r.is_query = (op == OP_QUERY);
    r.sum      = '0;
    r.dropped  = 1'b0;
    if (r.is_query) begin
      // Only the part of the range inside 1 to span counts; an empty range adds nothing.
      first = (lo == '0) ? 1 : int'(lo);
      last  = (int'(hi) > span) ? span : int'(hi);
      for (int p = first; p <= last; p++) r.sum += position_counts[p];
    end else if (pos == '0 || int'(pos) > span || grand_total == SUM_MAX) begin
      r.dropped = 1'b1;
    end else begin
      position_counts[pos] += 1'b1;
      grand_total          += 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
    mismatches++;
    $display("%0d ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    tree_result_t want;
    tree_result_t predicted;
    if (!rst_n) begin
      clear_counts();
      span = MAX_POSITIONS;
      expected_results.delete();
      mismatches         = 0;
      queries_checked    = 0;
      nonzero_sums       = 0;
      increments_checked = 0;
      drops_seen         = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_sum);
        end else begin
          want = expected_results.pop_front();
          if (out_sum !== want.sum)
            report_mismatch(want.is_query ? "query sum" : "increment sum", want.sum, out_sum);
          if (out_dropped !== want.dropped)
            report_mismatch("dropped flag", SUM_W'(want.dropped), SUM_W'(out_dropped));
          if (want.is_query) begin
            queries_checked++;
            if (want.sum != '0) nonzero_sums++;
          end else begin
            increments_checked++;
            if (want.dropped) drops_seen++;
          end
        end
      end
      // A size write clears every counter along with reshaping the tree.
      if (cfg_we) begin
        span = span_of(cfg_wdata);
        clear_counts();
      end
      if (in_valid && in_ready) begin
        predicted = predict_result(in_op, in_position, in_range_low, in_range_high);
        expected_results.insert(expected_results.size(), predicted);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### tb/point_count_range_sum_tree_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the point-count range-sum unit: clock, reset, stimulus and the verdict.
// Depends on pcrs_pkg, the unit itself and pcrs_tree_checker, which predicts and compares.
module point_count_range_sum_tree_unit_tb import pcrs_pkg::*;;

  localparam int   MAX_POSITIONS = 1024;

  // Quiet wait after the last result, leaving the block idle before the size register is touched.
  localparam int SETTLE_CYCLES = 40;
  // The receiver's long hold-off, used once to back the block up against its input.
  localparam int HOLD_CYCLES   = 300;
  // The longest correct stretch without a transaction is a settle wait followed by a clearing
  // pass, or the long hold-off; this is several times that.
  localparam int STALL_LIMIT   = 6000;

  typedef logic [FIELD_W-1:0] field_t;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             cfg_we        = 1'b0;
  field_t           cfg_wdata     = '0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic             in_op         = 1'b0;
  field_t           in_position   = '0;
  field_t           in_range_low  = '0;
  field_t           in_range_high = '0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic [SUM_W-1:0] out_sum;
  logic             out_dropped;

  int mismatches;
  int outstanding;
  int queries_checked;
  int nonzero_sums;
  int increments_checked;
  int drops_seen;

  // Run control shared between the sender and the receiver.
  bit tail_mode    = 1'b0;  // no idling on either side in the last phase
  bit hold_request = 1'b0;  // asks the receiver for its long hold-off
  int items_sent   = 0;
  int size_writes  = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  point_count_range_sum_tree_unit #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_position  (in_position),
    .in_range_low (in_range_low),
    .in_range_high(in_range_high),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sum      (out_sum),
    .out_dropped  (out_dropped)
  );

  pcrs_tree_checker #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_position       (in_position),
    .in_range_low      (in_range_low),
    .in_range_high     (in_range_high),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sum           (out_sum),
    .out_dropped       (out_dropped),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .queries_checked   (queries_checked),
    .nonzero_sums      (nonzero_sums),
    .increments_checked(increments_checked),
    .drops_seen        (drops_seen)
  );

  // Offers one transaction and returns at the edge where it is accepted. Here valid is only
  // lowered when an idle burst is inserted in front of the next transaction, so it never
  // drops and rises within the same time step.
  task automatic send_item(logic op, field_t pos, field_t lo, field_t hi);
    if (!tail_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_position   <= pos;
    in_range_low  <= lo;
    in_range_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Random transaction shaped by the number of positions in use: most increments land on a
  // valid position and most queries ask for a sensible range around the covered span, while
  // the rest use position zero, either-order ranges or raw 11-bit values past the ends.
  task automatic random_item(int span);
    logic   op;
    field_t pos;
    field_t lo;
    field_t hi;
    int     pick;
    op   = ($urandom_range(0, 99) < 55) ? OP_INC : OP_QUERY;
    pos  = field_t'($urandom);
    lo   = field_t'($urandom);
    hi   = field_t'($urandom);
    pick = $urandom_range(0, 99);
    if (op == OP_INC) begin
      if (pick < 85) pos = field_t'($urandom_range(1, span));
      else if (pick < 90) pos = '0;
    end else if (pick < 75) begin
      lo = field_t'($urandom_range(0, span + 1));
      hi = field_t'($urandom_range(32'(lo), span + 1));
    end else if (pick < 90) begin
      // Either order, so empty ranges turn up regularly.
      lo = field_t'($urandom_range(0, span + 1));
      hi = field_t'($urandom_range(0, span + 1));
    end
    send_item(op, pos, lo, hi);
  endtask

  // Waits until every expected result has come back and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One phase: a size write while the block is idle, then a batch of random transactions.
  // The write starts a clearing pass; the sender simply waits on in_ready through it.
  task automatic run_phase(field_t size_value, int count, bit with_hold);
    int span;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= size_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_writes++;
    span = (size_value == '0) ? 1 :
           (int'(size_value) > MAX_POSITIONS) ? MAX_POSITIONS : int'(size_value);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 4) hold_request = 1'b1;
      random_item(span);
    end
  endtask

  // Receiver: mostly ready, with random stall bursts, and the one long hold-off on request.
  initial begin : receiver
    int burst;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (!tail_mode && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, run abandoned", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 1024 positions, starting from an empty tree.
    send_item(OP_QUERY, '0, 11'd1, 11'd1024);       // whole span while everything is zero
    send_item(OP_INC, 11'd1, '0, '0);               // lowest position
    send_item(OP_INC, 11'd1024, '0, '0);            // highest position
    send_item(OP_INC, 11'd0, '0, '0);               // position zero is dropped
    send_item(OP_INC, 11'd1025, '0, '0);            // just past the span, dropped
    send_item(OP_INC, 11'd2047, 11'd2047, 11'd2047); // all ones, dropped
    send_item(OP_INC, 11'd512, '0, '0);             // either side of the root split
    send_item(OP_INC, 11'd513, '0, '0);
    send_item(OP_INC, 11'd513, '0, '0);
    send_item(OP_QUERY, '0, 11'd0, 11'd1025);       // range past both ends
    send_item(OP_QUERY, 11'd2047, 11'd0, 11'd2047); // widest field values
    send_item(OP_QUERY, '0, 11'd1024, 11'd1);       // empty range
    send_item(OP_QUERY, '0, 11'd1, 11'd1);
    send_item(OP_QUERY, '0, 11'd1024, 11'd1024);
    send_item(OP_QUERY, '0, 11'd513, 11'd512);      // empty, adjacent ends
    send_item(OP_QUERY, '0, 11'd512, 11'd513);      // straddles the root split
    send_item(OP_QUERY, '0, 11'd0, 11'd0);          // nothing but position zero
    send_item(OP_QUERY, '0, 11'd2047, 11'd2047);    // wholly beyond the span
    send_item(OP_QUERY, '0, 11'd1025, 11'd1025);
    send_item(OP_QUERY, 11'd2047, 11'd2, 11'd1023); // interior only
    send_item(OP_QUERY, '0, 11'd1, 11'd1024);

    // Random phases over a spread of sizes: the extremes, zero (acts as one), values above
    // the maximum (act as the maximum) and a few in between. Small spans pile increments
    // onto few positions so that query sums grow well beyond one.
    run_phase(11'd1, 50, 1'b0);
    run_phase(11'd0, 50, 1'b0);
    run_phase(11'd2047, 50, 1'b0);
    run_phase(11'd37, 55, 1'b1);  // the long receiver hold-off falls in this phase
    run_phase(11'd2, 50, 1'b0);
    run_phase(11'd1025, 50, 1'b0);
    run_phase(11'd300, 50, 1'b0);
    settle();
    tail_mode = 1'b1;
    run_phase(11'd1024, 50, 1'b0);

    settle();
    $display("Covered %0d transactions over %0d size settings, including one %0d-cycle hold-off.",
             items_sent, size_writes + 1, HOLD_CYCLES);
    $display("Checked %0d range queries (%0d non-zero) and %0d increments (%0d dropped).",
             queries_checked, nonzero_sums, increments_checked, drops_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### point_count_range_sum_tree_unit.f
rtl/core/pcrs_pkg.sv
rtl/core/pcrs_alu.sv
rtl/core/pcrs_walk.sv
rtl/core/pcrs_seq.sv
rtl/core/point_count_range_sum_tree_unit.sv
tb/pcrs_tree_checker.sv
tb/point_count_range_sum_tree_unit_tb.sv
